[hw/rtl/cse3_pkg.sv]
package cse3_pkg;

    localparam int unsigned CoefW = 32;
    localparam int unsigned AccW  = 48;
    localparam int unsigned YW    = 33;

    typedef enum logic [1:0] {
        REG_DEGREE = 2'd0,
        REG_MID    = 2'd1,
        REG_INVHW  = 2'd2
    } t_reg_idx;

    typedef enum logic {
        ACT_LOAD = 1'b0,
        ACT_EVAL = 1'b1
    } t_action;

    typedef struct packed {
        logic              action;
        logic [3:0]        coef_index;
        logic signed [31:0] coef_longitude;
        logic signed [31:0] coef_latitude;
        logic signed [31:0] coef_distance;
        logic signed [31:0] sample_time;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] longitude;
        logic signed [31:0] latitude;
        logic signed [31:0] distance;
        logic               out_of_interval;
    } t_out_item;

    // Control handed from the sequencer to each channel cell.
    typedef struct packed {
        logic start;
        logic mlo;
        logic step;
        logic fin;
    } t_cell_ctl;

endpackage

[hw/rtl/cse3_cell.sv]
module cse3_cell (
    input  logic                               i_clk,
    input  cse3_pkg::t_cell_ctl                i_ctl,
    input  logic signed [cse3_pkg::YW-1:0]     i_y,
    input  logic signed [31:0]                 i_coef,
    output logic signed [31:0]                 o_result
);
    localparam int unsigned AW = cse3_pkg::AccW;
    localparam int unsigned YW = cse3_pkg::YW;
    localparam int unsigned HW = AW / 2;
    localparam int unsigned PW = HW + YW;

    logic signed [AW-1:0] r_u, r_v, n_u;
    logic signed [31:0]   r_res;
    logic [AW-1:0]        w_am;
    logic [YW-1:0]        w_ym;
    logic [PW-1:0]        r_pl, w_ph;
    logic [AW+YW-1:0]     w_pfull;
    logic [AW+1:0]        w_pmag;
    logic signed [AW+1:0] w_p;
    logic signed [AW+3:0] w_sum, w_fin, w_half;

    // round(u*y/2^30), half away from zero; |u|*|y| is built from two halves,
    // the low half registered in the cycle before the high half is formed
    assign w_am    = r_u[AW-1] ? AW'(-r_u) : AW'(r_u);
    assign w_ym    = i_y[YW-1] ? YW'(-i_y) : YW'(i_y);
    assign w_ph    = PW'(w_am[AW-1:HW]) * PW'(w_ym);
    assign w_pfull = ((AW+YW)'(w_ph) << HW) + (AW+YW)'(r_pl) + (AW+YW)'(64'd1 << 29);
    assign w_pmag  = w_pfull[AW+31:30];
    assign w_p     = (r_u[AW-1] ^ i_y[YW-1]) ? -$signed(w_pmag) : $signed(w_pmag);

    assign w_sum = (AW+4)'(w_p) - (AW+4)'(r_v) + (AW+4)'(i_coef);
    assign w_fin = (AW+4)'(w_p) - ((AW+4)'(r_v) <<< 1) + (AW+4)'(i_coef) + (AW+4)'(1);
    assign w_half = w_fin >>> 1;

    always_comb begin
        if (w_sum > (AW+4)'((64'sd1 <<< (AW-1)) - 1)) begin
            n_u = {1'b0, {(AW-1){1'b1}}};
        end else if (w_sum < -(AW+4)'(64'sd1 <<< (AW-1))) begin
            n_u = {1'b1, {(AW-1){1'b0}}};
        end else begin
            n_u = AW'(w_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mlo) begin
            r_pl <= PW'(w_am[HW-1:0]) * PW'(w_ym);
        end
        if (i_ctl.start) begin
            r_u <= '0;
            r_v <= '0;
        end else if (i_ctl.step) begin
            r_u <= n_u;
            r_v <= r_u;
        end
        if (i_ctl.fin) begin
            if (w_half > (AW+4)'(32'sh7fffffff)) begin
                r_res <= 32'sh7fffffff;
            end else if (w_half < -(AW+4)'(33'sh080000000)) begin
                r_res <= 32'sh80000000;
            end else begin
                r_res <= 32'(w_half);
            end
        end
    end

    assign o_result = r_res;
endmodule

[hw/rtl/chebyshev_series_eval_three_channel_top.sv]
// Channel   Dir  Handshake        Payload
// ------------------------------------------------------------
// in        in   i_valid/o_stall  cse3_pkg::t_in_item
// out       out  o_valid/i_stall  cse3_pkg::t_out_item
// cfg       in   i_cfg_we         i_cfg_index, i_cfg_data
//
// A load writes its table entry while the sequencer stays idle. An evaluate, once
// accepted, does the mapping multiply, then each Clenshaw step and the final step
// in two phases (low and high half of the cell multiply), then moves the result
// into the output register, after which the next item is accepted.
// Reset (synchronous, i_rst_n low) clears the sequencer and output valid, presets
// the config registers; the coefficient table is undefined until loaded.
// A finished result sits in the output register; the next item is accepted
// while it waits, but a new result holds, and stalls the input, until the old
// one is taken.
module chebyshev_series_eval_three_channel_top #(
    parameter int unsigned MAX_TERMS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  cse3_pkg::t_in_item  i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output cse3_pkg::t_out_item o_data,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);
    localparam int unsigned IW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int unsigned YW = cse3_pkg::YW;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MAP  = 4'b0010,
        ST_RUN  = 4'b0100,
        ST_FIN  = 4'b1000
    } t_state;

    t_state r_state;
    logic [3:0]  r_degree;
    logic signed [31:0] r_mid;
    logic [31:0] r_invhw;
    logic [IW-1:0] r_k;
    logic r_ph;
    logic signed [32:0] r_d;
    logic signed [YW-1:0] r_y;
    logic r_clamp, r_out_valid, r_pend;
    cse3_pkg::t_out_item r_out;

    logic signed [31:0] r_tab_lon [MAX_TERMS];
    logic signed [31:0] r_tab_lat [MAX_TERMS];
    logic signed [31:0] r_tab_dst [MAX_TERMS];

    logic w_acc_in, w_out_take;
    logic [32:0] w_dm;
    logic [65:0] w_prod;
    logic [56:0] w_ym;
    logic [IW-1:0] w_kstart;
    cse3_pkg::t_cell_ctl w_ctl;
    logic signed [31:0] w_lon, w_lat, w_dst;

    assign o_stall    = (r_state != ST_IDLE) || r_pend;
    assign w_acc_in   = i_valid && !o_stall;
    assign w_out_take = r_out_valid && !i_stall;

    // Limit degree to the table depth.
    assign w_kstart = (32'(r_degree) > MAX_TERMS - 1) ? IW'(MAX_TERMS - 1) : IW'(r_degree);

    assign w_dm   = r_d[32] ? 33'(-r_d) : 33'(r_d);
    assign w_prod = 66'(w_dm) * 66'(r_invhw);
    assign w_ym   = 57'((w_prod + 66'd256) >> 9);

    // Each step forms the low half of the product (mlo), then finishes (step, or fin on the last).
    assign w_ctl.start = (r_state == ST_MAP);
    assign w_ctl.mlo   = (r_state == ST_RUN) && !r_ph;
    assign w_ctl.step  = (r_state == ST_RUN) && r_ph && (r_k != '0);
    assign w_ctl.fin   = (r_state == ST_FIN) || ((r_state == ST_RUN) && r_ph && (r_k == '0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_degree    <= 4'd15;
            r_mid       <= '0;
            r_invhw     <= 32'd16777216;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    cse3_pkg::REG_DEGREE: r_degree <= i_cfg_data[3:0];
                    cse3_pkg::REG_MID:    r_mid    <= i_cfg_data;
                    cse3_pkg::REG_INVHW:  r_invhw  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_out_take) begin
                r_out_valid <= 1'b0;
            end
            // Move a parked result into the output register.
            if (r_pend && (!r_out_valid || w_out_take)) begin
                r_out_valid <= 1'b1;
                r_out       <= '{w_lon, w_lat, w_dst, r_clamp};
                r_pend      <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_acc_in) begin
                        if (i_data.action == cse3_pkg::ACT_EVAL) begin
                            r_d     <= 33'(i_data.sample_time) - 33'(r_mid);
                            r_state <= ST_MAP;
                        end else if (32'(i_data.coef_index) < MAX_TERMS) begin
                            r_tab_lon[IW'(i_data.coef_index)] <= i_data.coef_longitude;
                            r_tab_lat[IW'(i_data.coef_index)] <= i_data.coef_latitude;
                            r_tab_dst[IW'(i_data.coef_index)] <= i_data.coef_distance;
                        end
                    end
                end
                ST_MAP: begin
                    r_clamp <= (w_ym > 57'(64'd1 << 31));
                    r_y <= (w_ym > 57'(64'd1 << 31))
                        ? (r_d[32] ? -YW'(64'd1 << 31) : YW'(64'd1 << 31))
                        : (r_d[32] ? -YW'(w_ym) : YW'(w_ym));
                    r_k     <= w_kstart;
                    r_ph    <= 1'b0;
                    r_state <= ST_RUN;
                end
                ST_RUN: begin
                    r_ph <= !r_ph;
                    if (r_ph) begin
                        if (r_k == '0) begin
                            r_pend  <= 1'b1;
                            r_state <= ST_IDLE;
                        end else begin
                            r_k <= r_k - IW'(1);
                        end
                    end
                end
                ST_FIN: r_state <= ST_IDLE;
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    cse3_cell u_lon (.i_clk, .i_ctl(w_ctl), .i_y(r_y), .i_coef(r_tab_lon[r_k]), .o_result(w_lon));
    cse3_cell u_lat (.i_clk, .i_ctl(w_ctl), .i_y(r_y), .i_coef(r_tab_lat[r_k]), .o_result(w_lat));
    cse3_cell u_dst (.i_clk, .i_ctl(w_ctl), .i_y(r_y), .i_coef(r_tab_dst[r_k]), .o_result(w_dst));

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

`ifndef SYNTH
    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> o_stall) else $error("accepted while busy");
    a_pend_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend && !r_out_valid) |=> r_out_valid) else $error("result lost");
    a_state_hot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("bad state");
`endif
endmodule
